### rtl/core/glyph_column_rasterizer_core_defines.svh
// ---------------------------------------------------------------------------
// glyph column rasterizer assertion macros
// shared concurrent check templates, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef GLYPH_COLUMN_RASTERIZER_CORE_DEFINES_SVH
`define GLYPH_COLUMN_RASTERIZER_CORE_DEFINES_SVH

// same-cycle implication
`define GCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gcr_pkg.sv
// ---------------------------------------------------------------------------
// gcr_pkg
// shared widths, register codes, reset values and structs of the rasterizer
// ---------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

  localparam int MAX_PANEL = 1024;
  localparam int GLYPH_W   = 8;
  localparam int COORD_W   = 10;
  localparam int PANEL_W   = 11;
  localparam int COLOR_W   = 16;
  localparam int SIZE_W    = 6;
  localparam int BIT_IDX_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // input queue between front and back
  localparam int QDEPTH = 2;
  localparam int PTR_W  = 1;
  localparam int CNT_W  = 2;

  localparam logic [SIZE_W-1:0]  RST_GLYPH_SIZE = 6'd16;
  localparam logic [COLOR_W-1:0] RST_FG_COLOR   = 16'hF800;
  localparam logic [COLOR_W-1:0] RST_BG_COLOR   = 16'hFFFF;
  localparam logic [PANEL_W-1:0] RST_PANEL_W    = 11'd240;
  localparam logic [PANEL_W-1:0] RST_PANEL_H    = 11'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_SIZE   = 3'd0,
    CFG_FG_COLOR     = 3'd1,
    CFG_BG_COLOR     = 3'd2,
    CFG_TRANSPARENT  = 3'd3,
    CFG_PANEL_WIDTH  = 3'd4,
    CFG_PANEL_HEIGHT = 3'd5
  } gcr_cfg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  glyph_size;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic               transparent;
    logic [PANEL_W-1:0] wmax;
    logic [PANEL_W-1:0] hmax;
  } gcr_cfg_t;

  // classified glyph byte as it sits in the queue
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [GLYPH_W-1:0] emit_mask;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic               first;
    logic               size_ok;
  } gcr_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
  } gcr_front_st_t;

  typedef struct packed {
    logic hold_v;
    logic hold_final;
    logic mid_byte;
  } gcr_back_st_t;

  function automatic logic size_renders(input logic [SIZE_W-1:0] s);
    return (s == 6'd12) || (s == 6'd16) || (s == 6'd24) || (s == 6'd32);
  endfunction

  function automatic logic [PANEL_W-1:0] cap_panel(input logic [PANEL_W-1:0] v);
    return (v > PANEL_W'(MAX_PANEL)) ? PANEL_W'(MAX_PANEL) : v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/gcr_ifs.sv
// ---------------------------------------------------------------------------
// gcr channel interfaces
// valid/ready channels for glyph bytes in and pixel writes out
// ---------------------------------------------------------------------------
`default_nettype none

interface gcr_in_if;
  import gcr_pkg::*;

  logic               valid;
  logic               ready;
  logic [GLYPH_W-1:0] glyph_byte;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic               first_byte;

  modport source (output valid, glyph_byte, start_x, start_y, first_byte, input ready);
  modport sink   (input valid, glyph_byte, start_x, start_y, first_byte, output ready);
endinterface

interface gcr_out_if;
  import gcr_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

`default_nettype wire

### rtl/core/glyph_column_rasterizer_core.sv
// path: each byte waits in the queue; its pixels pass the hold register and
//   the output register to out_ch, the last one flagged once its byte closes
// walk: one glyph bit per cycle in the back-end walker while the held pixel
//   can move on; a byte that halts, ends a column or renders nothing stops early
// reset: config back to 16 / 0xF800 / 0xFFFF / opaque / 240 x 320, cursor at 0,
//   character halted until a first byte, queue and output empty
`default_nettype none

`include "glyph_column_rasterizer_core_defines.svh"

// ---------------------------------------------------------------------------
// glyph_column_rasterizer_core
// turns column-major glyph bytes into RGB565 pixel writes on a panel
// ---------------------------------------------------------------------------
module glyph_column_rasterizer_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  gcr_in_if.sink                                    in_ch,
  gcr_out_if.source                                 out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [gcr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [gcr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import gcr_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0]  glyph_size_r;
  logic [COLOR_W-1:0] fg_color_r;
  logic [COLOR_W-1:0] bg_color_r;
  logic               transparent_r;
  logic [PANEL_W-1:0] panel_w_r;
  logic [PANEL_W-1:0] panel_h_r;

  gcr_cfg_t      cfg;
  gcr_item_t     q_item;
  logic          q_valid;
  logic          q_pop;
  gcr_front_st_t front_st;
  gcr_back_st_t  back_st;

  // writes to unknown indexes fall through and are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_size_r  <= RST_GLYPH_SIZE;
      fg_color_r    <= RST_FG_COLOR;
      bg_color_r    <= RST_BG_COLOR;
      transparent_r <= 1'b0;
      panel_w_r     <= RST_PANEL_W;
      panel_h_r     <= RST_PANEL_H;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GLYPH_SIZE:   glyph_size_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_FG_COLOR:     fg_color_r    <= cfg_wdata[COLOR_W-1:0];
        CFG_BG_COLOR:     bg_color_r    <= cfg_wdata[COLOR_W-1:0];
        CFG_TRANSPARENT:  transparent_r <= cfg_wdata[0];
        CFG_PANEL_WIDTH:  panel_w_r     <= cfg_wdata[PANEL_W-1:0];
        CFG_PANEL_HEIGHT: panel_h_r     <= cfg_wdata[PANEL_W-1:0];
        default: ;
      endcase
    end
  end

  // panel limits clamp to the largest supported panel
  always_comb begin
    cfg.glyph_size  = glyph_size_r;
    cfg.fg_color    = fg_color_r;
    cfg.bg_color    = bg_color_r;
    cfg.transparent = transparent_r;
    cfg.wmax        = cap_panel(panel_w_r);
    cfg.hmax        = cap_panel(panel_h_r);
  end

  // front end: takes byte beats, precomputes which bits paint, queues them
  gcr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .st      (front_st)
  );

  // back end: one bit per cycle against the cursor unless stalled, pixels out
  gcr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .st      (back_st)
  );

  // queue only takes a beat while it has room
  `GCR_ASSERT_NOW(a_queue_room, in_ch.valid && in_ch.ready, front_st.fill < CNT_W'(QDEPTH), "gcr queue overflow")
  // a byte being walked stays at the queue head
  `GCR_ASSERT_NOW(a_mid_byte_queued, back_st.mid_byte, front_st.fill != '0, "gcr walker lost its byte")
  // a closed byte only marks a held pixel
  `GCR_ASSERT_NOW(a_final_held, back_st.hold_final, back_st.hold_v, "gcr final flag without pixel")
  // a closed held pixel leaves as the byte's last beat when the output frees up
  `GCR_ASSERT_NEXT(a_last_out, back_st.hold_final && (!out_ch.valid || out_ch.ready), out_ch.valid && out_ch.last_pixel, "gcr last pixel not delivered")

endmodule

`default_nettype wire

### rtl/core/gcr_front.sv
// ---------------------------------------------------------------------------
// gcr_front
// accepts glyph bytes, classifies their bits and queues them for the walker
// ---------------------------------------------------------------------------
`default_nettype none

module gcr_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  gcr_in_if.sink                  in_ch,
  input  wire gcr_pkg::gcr_cfg_t  cfg,
  output gcr_pkg::gcr_item_t      q_item,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output gcr_pkg::gcr_front_st_t  st
);
  import gcr_pkg::*;

  gcr_item_t        mem_r [QDEPTH];
  gcr_item_t        new_item;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign in_ch.ready = (count_r != CNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_item      = mem_r[rd_ptr_r];
  assign st.fill     = count_r;

  // clear bits only emit when opaque
  always_comb begin
    new_item.glyph     = in_ch.glyph_byte;
    new_item.emit_mask = in_ch.glyph_byte | {GLYPH_W{~cfg.transparent}};
    new_item.start_x   = in_ch.start_x;
    new_item.start_y   = in_ch.start_y;
    new_item.first     = in_ch.first_byte;
    new_item.size_ok   = size_renders(cfg.glyph_size);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/gcr_back.sv
// ---------------------------------------------------------------------------
// gcr_back
// walks one glyph bit per cycle unless stalled, keeps cursor, drives pixels
// ---------------------------------------------------------------------------
`default_nettype none

module gcr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gcr_pkg::gcr_cfg_t   cfg,
  input  wire gcr_pkg::gcr_item_t  q_item,
  input  wire logic                q_valid,
  output logic                     q_pop,
  gcr_out_if.source                out_ch,
  output gcr_pkg::gcr_back_st_t    st
);
  import gcr_pkg::*;

  // cursor state
  logic [PANEL_W-1:0]   cursor_x_r, cursor_x_nxt;
  logic [PANEL_W-1:0]   cursor_y_r, cursor_y_nxt;
  logic [COORD_W-1:0]   top_row_r, top_row_nxt;
  logic                 halted_r, halted_nxt;
  logic [BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;

  // held pixel, waits until it is known whether it closes the byte
  logic                 hold_v_r, hold_v_nxt;
  logic                 hold_final_r, hold_final_nxt;
  logic [COORD_W-1:0]   hold_x_r, hold_x_nxt;
  logic [COORD_W-1:0]   hold_y_r, hold_y_nxt;
  logic [COLOR_W-1:0]   hold_c_r, hold_c_nxt;

  // output register
  logic                 out_v_r, out_v_nxt;
  logic [COORD_W-1:0]   out_x_r, out_x_nxt;
  logic [COORD_W-1:0]   out_y_r, out_y_nxt;
  logic [COLOR_W-1:0]   out_c_r, out_c_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 load;
  logic [PANEL_W-1:0]   eff_x, eff_y, x1, y1, col_diff;
  logic [COORD_W-1:0]   eff_top;
  logic                 halted_eff;
  logic                 skip;
  logic [GLYPH_W-1:0]   glyph_sh, emit_sh;
  logic                 pix_set, emit;
  logic                 hstop, col_end, wstop, byte_end;
  logic                 out_free, step, hold_move;

  always_comb begin
    load       = (bit_idx_r == '0) && q_item.first;
    eff_x      = load ? PANEL_W'(q_item.start_x) : cursor_x_r;
    eff_y      = load ? PANEL_W'(q_item.start_y) : cursor_y_r;
    eff_top    = load ? q_item.start_y : top_row_r;
    halted_eff = load ? 1'b0 : halted_r;
    skip       = halted_eff || !q_item.size_ok;

    glyph_sh   = q_item.glyph << bit_idx_r;
    emit_sh    = q_item.emit_mask << bit_idx_r;
    pix_set    = glyph_sh[GLYPH_W-1];
    emit       = q_valid && !skip && emit_sh[GLYPH_W-1];

    y1         = eff_y + PANEL_W'(1);
    x1         = eff_x + PANEL_W'(1);
    hstop      = (y1 >= cfg.hmax);
    col_diff   = y1 - PANEL_W'(eff_top);
    col_end    = !hstop && (col_diff == PANEL_W'(cfg.glyph_size));
    wstop      = (x1 >= cfg.wmax);
    byte_end   = skip || hstop || col_end || (bit_idx_r == {BIT_IDX_W{1'b1}});

    out_free   = !out_v_r || out_ch.ready;
    step       = q_valid && (!hold_v_r ||
                             (hold_final_r ? out_free : (!emit || out_free)));
    hold_move  = hold_v_r && out_free && (hold_final_r || (step && emit));
    q_pop      = step && byte_end;
  end

  // cursor walk
  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    top_row_nxt  = top_row_r;
    halted_nxt   = halted_r;
    bit_idx_nxt  = bit_idx_r;
    if (step) begin
      top_row_nxt = eff_top;
      bit_idx_nxt = byte_end ? '0 : bit_idx_r + BIT_IDX_W'(1);
      if (skip) begin
        cursor_x_nxt = eff_x;
        cursor_y_nxt = eff_y;
        halted_nxt   = halted_eff;
      end else if (hstop) begin
        cursor_x_nxt = eff_x;
        cursor_y_nxt = y1;
        halted_nxt   = 1'b1;
      end else if (col_end) begin
        cursor_x_nxt = x1;
        cursor_y_nxt = PANEL_W'(eff_top);
        halted_nxt   = wstop;
      end else begin
        cursor_x_nxt = eff_x;
        cursor_y_nxt = y1;
        halted_nxt   = 1'b0;
      end
    end
  end

  // hold stage
  always_comb begin
    hold_v_nxt     = hold_v_r;
    hold_final_nxt = hold_final_r;
    hold_x_nxt     = hold_x_r;
    hold_y_nxt     = hold_y_r;
    hold_c_nxt     = hold_c_r;
    if (step && emit) begin
      hold_v_nxt     = 1'b1;
      hold_final_nxt = byte_end;
      hold_x_nxt     = eff_x[COORD_W-1:0];
      hold_y_nxt     = eff_y[COORD_W-1:0];
      hold_c_nxt     = pix_set ? cfg.fg_color : cfg.bg_color;
    end else if (hold_move) begin
      hold_v_nxt     = 1'b0;
      hold_final_nxt = 1'b0;
    end else if (step && byte_end && hold_v_r) begin
      hold_final_nxt = 1'b1;
    end
  end

  // output register
  always_comb begin
    out_v_nxt    = out_v_r;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_c_nxt    = out_c_r;
    out_last_nxt = out_last_r;
    if (hold_move) begin
      out_v_nxt    = 1'b1;
      out_x_nxt    = hold_x_r;
      out_y_nxt    = hold_y_r;
      out_c_nxt    = hold_c_r;
      out_last_nxt = hold_final_r;
    end else if (out_ch.ready) begin
      out_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      top_row_r    <= '0;
      halted_r     <= 1'b1;
      bit_idx_r    <= '0;
      hold_v_r     <= 1'b0;
      hold_final_r <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      top_row_r    <= top_row_nxt;
      halted_r     <= halted_nxt;
      bit_idx_r    <= bit_idx_nxt;
      hold_v_r     <= hold_v_nxt;
      hold_final_r <= hold_final_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_x_r   <= hold_x_nxt;
    hold_y_r   <= hold_y_nxt;
    hold_c_r   <= hold_c_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_c_r    <= out_c_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_color = out_c_r;
  assign out_ch.last_pixel  = out_last_r;

  assign st.hold_v     = hold_v_r;
  assign st.hold_final = hold_final_r;
  assign st.mid_byte   = (bit_idx_r != '0);

endmodule

`default_nettype wire

### test/glyph_column_rasterizer_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glyph_column_rasterizer_core_tb
// drives glyph bytes through the valid/ready input channel under random
// source gaps and sink stalls, predicts every pixel write in step with the
// design's register settings and checks each pixel beat field by field
// ---------------------------------------------------------------------------
module glyph_column_rasterizer_core_tb;
  import gcr_pkg::*;

  // idle cycles before a register write, covers a queue of non-emitting bytes
  localparam int SETTLE_CYCLES = 40;
  // cycles without any beat on either channel before the run is abandoned
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_GAP       = 18;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES   = 34;

  // register slots past the last defined one, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_write_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gcr_in_if  in_ch ();
  gcr_out_if out_ch ();

  glyph_column_rasterizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies as the design should hold them
  logic [SIZE_W-1:0]  reg_size        = RST_GLYPH_SIZE;
  logic [COLOR_W-1:0] reg_fg          = RST_FG_COLOR;
  logic [COLOR_W-1:0] reg_bg          = RST_BG_COLOR;
  logic               reg_transparent = 1'b0;
  logic [PANEL_W-1:0] reg_width       = RST_PANEL_W;
  logic [PANEL_W-1:0] reg_height      = RST_PANEL_H;

  // pen state of the character being drawn
  logic [15:0] pen_x       = '0;
  logic [15:0] pen_y       = '0;
  logic [15:0] col_top     = '0;
  logic        char_halted = 1'b1;

  pixel_write_t pending_pixels[$];

  // when set, neither side inserts gaps or stalls
  bit steady = 1'b0;

  int mismatches    = 0;
  int pixels_seen   = 0;
  int bytes_sent    = 0;
  int settings_used = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected pixels of one accepted glyph byte, walked MSB first
  function automatic void rasterize_byte(input logic [GLYPH_W-1:0] glyph,
                                         input logic [COORD_W-1:0] sx,
                                         input logic [COORD_W-1:0] sy,
                                         input logic first);
    pixel_write_t walk [GLYPH_W];
    logic [15:0]  wmax;
    logic [15:0]  hmax;
    logic         lit;
    int           n;
    n = 0;
    wmax = 16'(reg_width);
    hmax = 16'(reg_height);
    if (wmax > 16'(MAX_PANEL)) wmax = 16'(MAX_PANEL);
    if (hmax > 16'(MAX_PANEL)) hmax = 16'(MAX_PANEL);
    // a first byte reloads the pen even when the size renders nothing
    if (first) begin
      pen_x = 16'(sx);
      pen_y = 16'(sy);
      col_top = 16'(sy);
      char_halted = 1'b0;
    end
    if (char_halted || !(reg_size inside {6'd12, 6'd16, 6'd24, 6'd32})) return;
    for (int b = 0; b < GLYPH_W; b++) begin
      lit = glyph[GLYPH_W-1-b];
      if (lit || !reg_transparent) begin
        walk[n].x = pen_x[COORD_W-1:0];
        walk[n].y = pen_y[COORD_W-1:0];
        walk[n].color = lit ? reg_fg : reg_bg;
        walk[n].last = 1'b0;
        n++;
      end
      pen_y = pen_y + 16'd1;
      if (pen_y >= hmax) begin
        char_halted = 1'b1;
        break;
      end
      // column ends only on an exact match, a shrunk size runs to the bottom
      if (16'(pen_y - col_top) == 16'(reg_size)) begin
        pen_y = col_top;
        pen_x = pen_x + 16'd1;
        if (pen_x >= wmax) char_halted = 1'b1;
        break;
      end
    end
    if (n > 0) walk[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_pixels.push_back(walk[i]);
  endfunction

  // one byte beat; valid is left high so a back-to-back byte keeps it up
  task automatic push_glyph_byte(input logic [GLYPH_W-1:0] glyph,
                                 input logic [COORD_W-1:0] sx,
                                 input logic [COORD_W-1:0] sy,
                                 input logic first);
    int gap;
    gap = (steady || $urandom_range(1, 0) == 0) ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.glyph_byte <= glyph;
    in_ch.start_x    <= sx;
    in_ch.start_y    <= sy;
    in_ch.first_byte <= first;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    rasterize_byte(glyph, sx, sy, first);
    bytes_sent++;
  endtask

  // hold the source off until every pixel is out, then let stragglers finish
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_GLYPH_SIZE:   reg_size = value[SIZE_W-1:0];
      CFG_FG_COLOR:     reg_fg = value[COLOR_W-1:0];
      CFG_BG_COLOR:     reg_bg = value[COLOR_W-1:0];
      CFG_TRANSPARENT:  reg_transparent = value[0];
      CFG_PANEL_WIDTH:  reg_width = value[PANEL_W-1:0];
      CFG_PANEL_HEIGHT: reg_height = value[PANEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_panel(input logic [SIZE_W-1:0] size,
                               input logic [COLOR_W-1:0] fg,
                               input logic [COLOR_W-1:0] bg,
                               input logic transparent,
                               input logic [PANEL_W-1:0] width,
                               input logic [PANEL_W-1:0] height);
    write_reg(CFG_GLYPH_SIZE, CFG_DATA_W'(size));
    write_reg(CFG_FG_COLOR, fg);
    write_reg(CFG_BG_COLOR, bg);
    write_reg(CFG_TRANSPARENT, CFG_DATA_W'(transparent));
    write_reg(CFG_PANEL_WIDTH, CFG_DATA_W'(width));
    write_reg(CFG_PANEL_HEIGHT, CFG_DATA_W'(height));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // out of reset the character is halted, a plain byte draws nothing
  task automatic test_halted_after_reset();
    push_glyph_byte(8'hFF, 10'd0, 10'd0, 1'b0);
  endtask

  // reset settings: 16 rows, red on white, opaque; two bytes close a column
  task automatic test_default_character();
    drain_pipeline();
    push_glyph_byte(8'hA5, 10'd0, 10'd0, 1'b1);
    push_glyph_byte(8'h3C, 10'd0, 10'd0, 1'b0);
  endtask

  // transparent mode skips clear bits, an empty byte then draws nothing
  task automatic test_transparent();
    drain_pipeline();
    write_reg(CFG_TRANSPARENT, 16'd1);
    write_reg(CFG_FG_COLOR, 16'hFFFF);
    write_reg(CFG_BG_COLOR, 16'h0000);
    push_glyph_byte(8'hFF, 10'd5, 10'd5, 1'b1);
    push_glyph_byte(8'h00, 10'd0, 10'd0, 1'b0);
    push_glyph_byte(8'h81, 10'd0, 10'd0, 1'b0);
    drain_pipeline();
    write_reg(CFG_TRANSPARENT, 16'd0);
    push_glyph_byte(8'h00, 10'd0, 10'd0, 1'b0);
  endtask

  // origin beyond the 240 x 320 panel: one pixel, then halted
  task automatic test_origin_outside();
    push_glyph_byte(8'hFF, 10'd1023, 10'd1023, 1'b1);
    push_glyph_byte(8'hFF, 10'd0, 10'd0, 1'b0);
  endtask

  // oversized panel clamps to the cap, a zero panel halts at once
  task automatic test_panel_limits();
    drain_pipeline();
    program_panel(6'd32, 16'hF800, 16'h001F, 1'b0, 11'd2047, 11'd2047);
    push_glyph_byte(8'hFF, 10'd1023, 10'd1016, 1'b1);
    push_glyph_byte(8'h5A, 10'd0, 10'd0, 1'b0);
    drain_pipeline();
    write_reg(CFG_GLYPH_SIZE, 16'd12);
    push_glyph_byte(8'hF0, 10'd1023, 10'd0, 1'b1);
    push_glyph_byte(8'hFF, 10'd0, 10'd0, 1'b0);
    push_glyph_byte(8'hFF, 10'd0, 10'd0, 1'b0);
    drain_pipeline();
    write_reg(CFG_PANEL_WIDTH, 16'd0);
    write_reg(CFG_PANEL_HEIGHT, 16'd0);
    push_glyph_byte(8'h80, 10'd3, 10'd3, 1'b1);
  endtask

  // unsupported sizes draw nothing but a first byte still places the pen
  task automatic test_unsupported_size();
    drain_pipeline();
    program_panel(6'd0, 16'h07E0, 16'h0000, 1'b0, RST_PANEL_W, RST_PANEL_H);
    push_glyph_byte(8'hFF, 10'd10, 10'd20, 1'b1);
    drain_pipeline();
    write_reg(CFG_GLYPH_SIZE, 16'd63);
    push_glyph_byte(8'hFF, 10'd0, 10'd0, 1'b0);
    drain_pipeline();
    write_reg(CFG_GLYPH_SIZE, 16'd24);
    push_glyph_byte(8'hC3, 10'd0, 10'd0, 1'b0);
  endtask

  // size shrunk below the row offset: the column never closes, height halts
  task automatic test_size_change();
    drain_pipeline();
    write_reg(CFG_GLYPH_SIZE, 16'd32);
    write_reg(CFG_PANEL_HEIGHT, 16'd40);
    push_glyph_byte(8'hAA, 10'd2, 10'd0, 1'b1);
    push_glyph_byte(8'h55, 10'd0, 10'd0, 1'b0);
    drain_pipeline();
    write_reg(CFG_GLYPH_SIZE, 16'd12);
    repeat (4) push_glyph_byte(8'($urandom), 10'd0, 10'd0, 1'b0);
  endtask

  // writes to undefined register slots leave every setting alone
  task automatic test_unknown_register();
    drain_pipeline();
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    push_glyph_byte(8'h96, 10'd7, 10'd9, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [PANEL_W-1:0] pick_panel();
    case ($urandom_range(9, 0))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd1024;
      3:       return 11'd2047;
      4:       return 11'($urandom_range(2047, 1025));
      default: return 11'($urandom_range(1024, 16));
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(5, 0))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // well-formed character: first byte, then whole columns of random bits;
  // now and then cut short or interleaved with a stray byte
  task automatic send_character();
    int rows, per_col, cols, total, wcap, hcap, span_x, span_y;
    logic [COORD_W-1:0] sx, sy;
    logic [GLYPH_W-1:0] glyph;
    rows = (reg_size == 0) ? 1 : int'(reg_size);
    per_col = (rows + 7) / 8;
    cols = $urandom_range(6, 1);
    total = cols * per_col;
    if ($urandom_range(9, 0) == 0) total = $urandom_range(total, 1);
    wcap = (reg_width > MAX_PANEL) ? MAX_PANEL : int'(reg_width);
    hcap = (reg_height > MAX_PANEL) ? MAX_PANEL : int'(reg_height);
    span_x = (wcap > cols) ? wcap - cols : 0;
    span_y = (hcap > rows) ? hcap - rows : 0;
    if (span_x > 1023) span_x = 1023;
    if (span_y > 1023) span_y = 1023;
    case ($urandom_range(9, 0))
      0: begin
        sx = 10'($urandom);
        sy = 10'($urandom);
      end
      // near the right or bottom edge, runs into the halt
      1: begin
        sx = 10'(span_x + $urandom_range(cols, 0));
        sy = 10'(span_y + $urandom_range(rows, 0));
      end
      default: begin
        sx = 10'($urandom_range(span_x, 0));
        sy = 10'($urandom_range(span_y, 0));
      end
    endcase
    for (int i = 0; i < total; i++) begin
      case ($urandom_range(7, 0))
        0:       glyph = 8'h00;
        1:       glyph = 8'hFF;
        default: glyph = 8'($urandom);
      endcase
      if (i == 0) begin
        push_glyph_byte(glyph, sx, sy, 1'b1);
      end else if ($urandom_range(19, 0) == 0) begin
        push_glyph_byte(glyph, 10'($urandom), 10'($urandom), 1'($urandom));
      end else begin
        push_glyph_byte(glyph, 10'($urandom), 10'($urandom), 1'b0);
      end
    end
  endtask

  task automatic test_random_phases();
    int quota;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_pipeline();
      case (p)
        0: program_panel(6'd12, 16'h0000, 16'hFFFF, 1'b0, 11'd1024, 11'd1024);
        1: program_panel(6'd32, 16'hFFFF, 16'h0000, 1'b1, 11'd2047, 11'd2047);
        default: program_panel(
            ($urandom_range(4, 0) == 0) ? 6'($urandom) : 6'd4 << $urandom_range(3, 0) |
              6'd0,
            pick_color(), pick_color(), 1'($urandom), pick_panel(), pick_panel());
      endcase
      steady = ($urandom_range(3, 0) == 0);
      quota = bytes_sent + PHASE_BYTES;
      while (bytes_sent < quota) begin
        if ($urandom_range(5, 0) == 0) begin
          // stray byte, mostly ignored while halted
          push_glyph_byte(8'($urandom), 10'($urandom), 10'($urandom),
                          ($urandom_range(3, 0) == 0));
        end else begin
          send_character();
        end
        // let the sink run the pipeline dry now and then
        if ($urandom_range(19, 0) == 0) drain_pipeline();
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // pixel sink: random stalls, every beat checked against the oldest pixel
  // ---------------------------------------------------------------------------
  initial begin : pixel_sink
    int stall;
    pixel_write_t got;
    pixel_write_t want;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.x = out_ch.pixel_x;
        got.y = out_ch.pixel_y;
        got.color = out_ch.pixel_color;
        got.last = out_ch.last_pixel;
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel beat %0d with nothing pending: x=%0d y=%0d color=%h last=%0d",
                     pixels_seen, got.x, got.y, got.color, got.last);
        end else begin
          want = pending_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel beat %0d: got x=%0d y=%0d color=%h last=%0d, %s%0d y=%0d %s",
                       pixels_seen, got.x, got.y, got.color, got.last, "expected x=",
                       want.x, want.y, $sformatf("color=%h last=%0d", want.color,
                       want.last));
          end
        end
        // sink gap for the following beat, sometimes none at all
        stall = (steady || $urandom_range(1, 0) == 0) ? 0 : $urandom_range(MAX_GAP, 0);
      end else if (stall > 0) begin
        stall--;
      end
      out_ch.ready <= (stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without a beat on either channel ends the run
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("no beat for %0d cycles, %0d pixels still pending",
             QUIET_LIMIT, pending_pixels.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_GLYPH_SIZE;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.glyph_byte <= '0;
    in_ch.start_x    <= '0;
    in_ch.start_y    <= '0;
    in_ch.first_byte <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_halted_after_reset();
    test_default_character();
    test_transparent();
    test_origin_outside();
    test_panel_limits();
    test_unsupported_size();
    test_size_change();
    test_unknown_register();
    test_random_phases();

    // all bytes are in; wait for the last pixels and any late extras
    drain_pipeline();

    $display("sent %0d glyph bytes, checked %0d pixel beats over %0d register settings",
             bytes_sent, pixels_seen, settings_used);
    $display("mismatches %0d, pixels never produced %0d", mismatches,
             pending_pixels.size());
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/gcr_pkg.sv
rtl/core/gcr_ifs.sv
rtl/core/gcr_front.sv
rtl/core/gcr_back.sv
rtl/core/glyph_column_rasterizer_core.sv
test/glyph_column_rasterizer_core_tb.sv
